>>> rtl/core/bdeq_pkg.sv
// Shared codes, defaults and a helper function for the bounded deque core.
`timescale 1ns / 1ps

package bdeq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_R,
		OP_SHIFT_L,
		OP_APPEND,
		OP_DROP
	} cell_op_t;

	// Number of registered radix-8 levels needed to reduce depth leaves to one.
	function automatic int bdeq_levels(input int depth);
		int lv;
		lv = ($clog2(depth) + 2) / 3;
		if (lv < 1) begin
			lv = 1;
		end
		return lv;
	endfunction

endpackage

>>> rtl/core/bounded_double_ended_queue_core.sv
// Top level of the bounded deque: command decode, cell chain, back-word tree and result beat.
//
// The slave stream carries one command beat: tdata holds cmd in the lowest three bits and
// the data word above it. Every command beat produces exactly one result beat on the master
// stream, holding the front word, back word, occupancy, empty and full flags and a status
// code. Words are kept in a row of DEPTH cells with the front word always in the first cell;
// pushes and pops shift the whole row by one cell or set or clear the cell at the back end.
// The back word is gathered by a registered radix-8 OR tree of L = ceil(log2(DEPTH) / 3)
// levels, two for the default depth of sixteen.
// The cells and occupancy update on the edge that takes the command; the result beat is
// registered once the new back word has passed every tree level, as counted in the wait state.
// No new command is taken until that result beat has been registered.
// A new command is taken while the previous result waits only if that result is taken in the
// same cycle; while the master side stalls, the result beat holds and tready stays low.
// Reset empties the deque at once and clears the result valid; no clearing pass is needed.
// Push to a full deque and pop from an empty one leave the contents alone and report status.
`timescale 1ns / 1ps

module bounded_double_ended_queue_core
	import bdeq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IN_W = ((CMD_W + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_RAW_W = 2 * DATA_WIDTH + CNT_W + 2 + STATUS_W,
	localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd, data_in, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// front_word, back_word, occupancy, is_empty, is_full, status, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	localparam int LEVELS = bdeq_levels(DEPTH);
	localparam int WAIT_W = $clog2(LEVELS + 1);

	typedef enum logic {
		S_IDLE,
		S_WAIT
	} state_t;

	state_t                 state_q;
	logic [WAIT_W-1:0]      wait_q;
	logic [CNT_W-1:0]       count_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	logic [CMD_W-1:0]       cmd;
	logic [DATA_WIDTH-1:0]  din;
	logic                   accept;
	logic                   full;
	logic                   empty;
	cell_op_t               op;
	logic [CNT_W-1:0]       count_nxt;
	logic [STATUS_W-1:0]    status_nxt;

	logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
	logic [DEPTH-1:0]       cell_valid;
	logic [DATA_WIDTH-1:0]  back_tap [DEPTH];
	logic [DATA_WIDTH-1:0]  back_word;
	logic [OUT_RAW_W-1:0]   result;

	assign cmd = s_tdata[CMD_W-1:0];
	assign din = s_tdata[CMD_W+DATA_WIDTH-1:CMD_W];
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		op = OP_HOLD;
		count_nxt = count_q;
		status_nxt = STAT_DONE;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					op = (cmd == CMD_PUSH_FRONT) ? OP_SHIFT_R : OP_APPEND;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					op = (cmd == CMD_POP_FRONT) ? OP_SHIFT_L : OP_DROP;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				op = OP_HOLD;
			end
		endcase
		if (!accept) begin
			op = OP_HOLD;
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] l_data;
			logic                  l_valid;
			logic [DATA_WIDTH-1:0] r_data;
			logic                  r_valid;

			if (i == 0) begin : g_head
				assign l_data = din;
				assign l_valid = 1'b1;
			end else begin : g_mid_l
				assign l_data = cell_data[i-1];
				assign l_valid = cell_valid[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign r_data = '0;
				assign r_valid = 1'b0;
			end else begin : g_mid_r
				assign r_data = cell_data[i+1];
				assign r_valid = cell_valid[i+1];
			end

			bdeq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.op(op),
				.din(din),
				.left_data(l_data),
				.left_valid(l_valid),
				.right_data(r_data),
				.right_valid(r_valid),
				.data(cell_data[i]),
				.valid(cell_valid[i]),
				.back_tap(back_tap[i])
			);
		end
	endgenerate

	bdeq_or_tree #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_tree (
		.clk(clk),
		.leaf(back_tap),
		.root(back_word)
	);

	assign result = {status_q, full, empty, count_q, back_word, cell_data[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= '0;
			count_q <= '0;
			status_q <= STAT_DONE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_nxt;
						status_q <= status_nxt;
						wait_q <= WAIT_W'(LEVELS);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (wait_q == '0) begin
						m_tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wait_q <= wait_q - WAIT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && wait_q == '0) begin
			m_tdata_q <= OUT_W'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Occupancy exceeds the deque depth.");

	a_cells_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |-> $countones(cell_valid) == int'(count_q))
		else $error("Occupied cells disagree with the occupancy count.");

	a_front_cell_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> cell_valid[0])
		else $error("Deque holds words but the front cell is empty.");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
		|=> count_q == $past(count_q) && status_q == STAT_FULL)
		else $error("A push to a full deque changed the occupancy.");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("A second command was taken while one is in flight.");
`endif

endmodule

>>> rtl/core/bdeq_cell.sv
// One storage cell of the deque chain: a word, a valid bit and neighbor hand-off.
`timescale 1ns / 1ps

module bdeq_cell
	import bdeq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_op_t              op,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] back_tap
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_nxt;
	logic                  valid_nxt;

	always_comb begin
		data_nxt = data_q;
		valid_nxt = valid_q;
		case (op)
			OP_SHIFT_R: begin
				data_nxt = left_data;
				valid_nxt = left_valid;
			end
			OP_SHIFT_L: begin
				data_nxt = right_data;
				valid_nxt = right_valid;
			end
			OP_APPEND: begin
				if (!valid_q && left_valid) begin
					data_nxt = din;
					valid_nxt = 1'b1;
				end
			end
			OP_DROP: begin
				if (valid_q && !right_valid) begin
					valid_nxt = 1'b0;
				end
			end
			default: begin
				data_nxt = data_q;
				valid_nxt = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = valid_q ? data_q : '0;
	assign valid = valid_q;
	// The last occupied cell offers its word as the back of the deque.
	assign back_tap = (valid_q && !right_valid) ? data_q : '0;

endmodule

>>> rtl/core/bdeq_or_tree.sv
// Registered radix-8 OR reduction that gathers the back word from the cell taps.
`timescale 1ns / 1ps

module bdeq_or_tree
	import bdeq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] leaf [DEPTH],
	output logic [DATA_WIDTH-1:0] root
);

	localparam int LEVELS = bdeq_levels(DEPTH);
	localparam int SPAN = 1 << (3 * LEVELS);

	logic [DATA_WIDTH-1:0] lvl0 [SPAN];
	logic [DATA_WIDTH-1:0] node [1:LEVELS][SPAN];

	genvar l, k;
	generate
		for (k = 0; k < SPAN; k++) begin : g_leaf
			if (k < DEPTH) begin : g_used
				assign lvl0[k] = leaf[k];
			end else begin : g_pad
				assign lvl0[k] = '0;
			end
		end

		for (l = 1; l <= LEVELS; l++) begin : g_lvl
			for (k = 0; k < SPAN; k++) begin : g_node
				if (k < (SPAN >> (3 * l))) begin : g_used
					if (l == 1) begin : g_first
						always_ff @(posedge clk) begin
							node[l][k] <= lvl0[8*k]   | lvl0[8*k+1] | lvl0[8*k+2] |
								lvl0[8*k+3] | lvl0[8*k+4] | lvl0[8*k+5] |
								lvl0[8*k+6] | lvl0[8*k+7];
						end
					end else begin : g_upper
						always_ff @(posedge clk) begin
							node[l][k] <= node[l-1][8*k]   | node[l-1][8*k+1] |
								node[l-1][8*k+2] | node[l-1][8*k+3] |
								node[l-1][8*k+4] | node[l-1][8*k+5] |
								node[l-1][8*k+6] | node[l-1][8*k+7];
						end
					end
				end else begin : g_pad
					always_ff @(posedge clk) begin
						node[l][k] <= '0;
					end
				end
			end
		end
	endgenerate

	assign root = node[LEVELS][0];

endmodule

>>> tb/bounded_double_ended_queue_core_test.sv
// Self-checking testbench for the bounded deque core, with a shadow deque as the predictor.
`timescale 1ns / 1ps

module bounded_double_ended_queue_core_test;
	import bdeq_pkg::*;

	localparam int WORD_W = DATA_WIDTH_DEF;
	localparam int SLOT_COUNT = DEPTH_DEF;
	localparam int OCC_W = $clog2(DEPTH_DEF + 1);
	localparam int IN_W = ((CMD_W + WORD_W + 7) / 8) * 8;
	localparam int OUT_W = ((2 * WORD_W + OCC_W + 2 + STATUS_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] word;
	} deq_command_t;

	typedef struct {
		logic [WORD_W-1:0]   front_word;
		logic [WORD_W-1:0]   back_word;
		logic [OCC_W-1:0]    occupancy;
		logic                is_empty;
		logic                is_full;
		logic [STATUS_W-1:0] status;
	} deq_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	deq_command_t pending_cmds[$];
	deq_command_t next_cmd;
	deq_result_t  expected_results[$];
	logic [WORD_W-1:0] shadow_words[$];
	logic running = 1'b0;
	logic cmd_taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	logic [15:0] ready_pattern = 16'hffff;
	int   pattern_age = 0;
	int   error_count = 0;
	int   cycle_count = 0;

	bounded_double_ended_queue_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic deq_result_t apply_deq_command(input deq_command_t c);
		deq_result_t r;
		r.status = STAT_DONE;
		if (c.cmd == CMD_PUSH_FRONT || c.cmd == CMD_PUSH_BACK) begin
			if (shadow_words.size() >= SLOT_COUNT) begin
				r.status = STAT_FULL;
			end else if (c.cmd == CMD_PUSH_FRONT) begin
				shadow_words.push_front(c.word);
			end else begin
				shadow_words.push_back(c.word);
			end
		end else if (c.cmd == CMD_POP_FRONT || c.cmd == CMD_POP_BACK) begin
			if (shadow_words.size() == 0) begin
				r.status = STAT_EMPTY;
			end else if (c.cmd == CMD_POP_FRONT) begin
				void'(shadow_words.pop_front());
			end else begin
				void'(shadow_words.pop_back());
			end
		end
		if (shadow_words.size() == 0) begin
			r.front_word = '0;
			r.back_word = '0;
		end else begin
			r.front_word = shadow_words[0];
			r.back_word = shadow_words[shadow_words.size() - 1];
		end
		r.occupancy = OCC_W'(shadow_words.size());
		r.is_empty = (shadow_words.size() == 0);
		r.is_full = (shadow_words.size() >= SLOT_COUNT);
		return r;
	endfunction

	task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
		deq_command_t c;
		c.cmd = cmd;
		c.word = word;
		pending_cmds.push_back(c);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) begin
			return '0;
		end else if (k == 1) begin
			return '1;
		end
		return WORD_W'($urandom);
	endfunction

	always @(negedge clk) begin
		if (running && (!s_tvalid || cmd_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				s_tdata <= {{(IN_W - CMD_W - WORD_W){1'b0}}, next_cmd.word, next_cmd.cmd};
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		logic [15:0] pat;
		if (running) begin
			pat = {ready_pattern[0], ready_pattern[15:1]};
			if (pattern_age >= 150) begin
				case ($urandom_range(0, 2))
					0: pat = 16'hffff;
					1: pat = 16'($urandom) | 16'h0001;
					default: pat = 16'($urandom & $urandom) | 16'h0001;
				endcase
				pattern_age <= 0;
			end else begin
				pattern_age <= pattern_age + 1;
			end
			ready_pattern <= pat;
			m_tready <= pat[0];
		end
	end

	always @(posedge clk) begin
		deq_result_t got;
		deq_result_t want;
		deq_command_t c;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			got.front_word = m_tdata[WORD_W-1:0];
			got.back_word = m_tdata[2*WORD_W-1:WORD_W];
			got.occupancy = m_tdata[2*WORD_W +: OCC_W];
			got.is_empty = m_tdata[2*WORD_W + OCC_W];
			got.is_full = m_tdata[2*WORD_W + OCC_W + 1];
			got.status = m_tdata[2*WORD_W + OCC_W + 2 +: STATUS_W];
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, got %h", $time, m_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.front_word !== want.front_word) begin
					$display("%0t: front_word expected %h got %h", $time,
						want.front_word, got.front_word);
					error_count++;
				end
				if (got.back_word !== want.back_word) begin
					$display("%0t: back_word expected %h got %h", $time,
						want.back_word, got.back_word);
					error_count++;
				end
				if (got.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d got %0d", $time,
						want.occupancy, got.occupancy);
					error_count++;
				end
				if (got.is_empty !== want.is_empty) begin
					$display("%0t: is_empty expected %b got %b", $time,
						want.is_empty, got.is_empty);
					error_count++;
				end
				if (got.is_full !== want.is_full) begin
					$display("%0t: is_full expected %b got %b", $time,
						want.is_full, got.is_full);
					error_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, got.status);
					error_count++;
				end
			end
		end
		cmd_taken = s_tvalid && s_tready;
		if (cmd_taken) begin
			c.cmd = s_tdata[CMD_W-1:0];
			c.word = s_tdata[CMD_W +: WORD_W];
			expected_results.push_back(apply_deq_command(c));
		end
	end

	initial begin
		int made;
		int seg;
		int push_pct;
		int r;
		logic [CMD_W-1:0] cmd;

		add_cmd(CMD_QUERY, '1);
		add_cmd(CMD_POP_FRONT, '1);
		add_cmd(CMD_POP_BACK, '0);
		add_cmd(CMD_PUSH_BACK, '1);
		add_cmd(CMD_POP_BACK, '0);
		add_cmd(CMD_PUSH_FRONT, '0);
		add_cmd(CMD_POP_FRONT, '1);
		add_cmd(CMD_PUSH_FRONT, '1);
		add_cmd(CMD_PUSH_BACK, '0);
		add_cmd(CMD_SPARE5, 32'h5a5a_a5a5);
		add_cmd(CMD_SPARE6, 32'ha5a5_5a5a);
		add_cmd(CMD_SPARE7, '1);
		add_cmd(CMD_POP_BACK, '0);
		add_cmd(CMD_POP_FRONT, '0);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			add_cmd((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, WORD_W'($urandom));
		end
		add_cmd(CMD_PUSH_FRONT, '1);
		add_cmd(CMD_PUSH_BACK, '1);
		add_cmd(CMD_QUERY, '0);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			seg = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			for (int i = 0; i < seg; i++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					cmd = CMD_W'($urandom_range(CMD_QUERY, CMD_SPARE7));
				end else if (r < 4 + push_pct * 96 / 100) begin
					cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				end else begin
					cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				end
				add_cmd(cmd, pick_word());
				made++;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		running = 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
